[rtl/core/spq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stable priority queue.
// No dependencies; every other file of the block imports this package.
package spq_pkg;

  localparam int DATA_W       = 32;
  localparam int OCC_W        = 5;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // One held pair
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cmd_t;

endpackage

[rtl/core/spq_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result beats.
// Depends on spq_pkg for field widths.
interface spq_in_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [DATA_W-1:0] item_data;
  logic signed [DATA_W-1:0] item_priority;

  modport source (output valid, req_type, item_data, item_priority, input ready);
  modport sink   (input valid, req_type, item_data, item_priority, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] out_data;
  logic signed [DATA_W-1:0] out_priority;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, out_data, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_data, out_priority, occupancy, output ready);
endinterface

[rtl/core/stable_priority_queue.sv]
`timescale 1ns / 1ps
// Top level of the stable priority queue: a row of spq_cell slots plus count and result register.
// Depends on spq_pkg, spq_in_if / spq_out_if and spq_cell.
//
// The queue holds up to CAPACITY data/priority pairs sorted by descending signed
// priority; equal priorities keep arrival order. Each request beat (insert or
// remove) yields exactly one result beat, registered, on the following cycle.
// Throughput is one request per cycle while results are drained: every slot
// compares its priority with the incoming one in parallel and either holds,
// takes the new item, or takes its neighbour's pair, so no search loop exists.
// A new request is taken whenever the result register is empty or being
// drained in the same cycle. Remove on an empty queue returns status empty,
// insert on a full queue drops the item with status full; in both cases and on
// insert the data and priority fields read zero. Occupancy gives the count
// after the request, low five bits. Slot contents are not reset; only slots
// below the count are ever read.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_bus,
  spq_out_if.source out_bus
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      status_r;
  logic [STATUS_W-1:0]      status_nxt;
  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic signed [DATA_W-1:0] prio_r;
  logic signed [DATA_W-1:0] prio_nxt;
  logic [OCC_W-1:0]         occ_r;

  logic   fire;
  logic   full;
  logic   empty;
  cmd_t   cmd;

  entry_t ent  [CAPACITY];
  logic   disp [CAPACITY];

  // Take a beat whenever the result register is free or draining
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign fire         = in_bus.valid && in_bus.ready;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  assign cmd.ins       = fire && (in_bus.req_type == REQ_INSERT) && !full;
  assign cmd.rem       = fire && (in_bus.req_type == REQ_REMOVE) && !empty;
  assign cmd.item.data = in_bus.item_data;
  assign cmd.item.prio = in_bus.item_priority;

  // Row of slots, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   prev_disp_w;
    entry_t prev_ent_w;
    entry_t next_ent_w;

    if (i == 0) begin : g_head
      assign prev_disp_w = 1'b0;
      assign prev_ent_w  = cmd.item;
    end else begin : g_body
      assign prev_disp_w = disp[i-1];
      assign prev_ent_w  = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_ent_w = ent[i];
    end else begin : g_mid
      assign next_ent_w = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (count_r > CNT_W'(i)),
      .prev_disp (prev_disp_w),
      .prev_ent  (prev_ent_w),
      .next_ent  (next_ent_w),
      .disp      (disp[i]),
      .ent       (ent[i])
    );
  end

  // Count and result for the beat being taken
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_INSERTED;
    data_nxt   = '0;
    prio_nxt   = '0;
    unique case (in_bus.req_type)
      REQ_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_REMOVED;
          data_nxt   = ent[0].data;
          prio_nxt   = ent[0].prio;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_INSERTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on each taken beat, hold otherwise
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      prio_r   <= prio_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = status_r;
  assign out_bus.out_data     = data_r;
  assign out_bus.out_priority = prio_r;
  assign out_bus.occupancy    = occ_r;

endmodule

[rtl/core/spq_cell.sv]
`timescale 1ns / 1ps
// One slot of the sorted row: holds a pair and trades it with its neighbours.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk,
  input  cmd_t   cmd,
  input  logic   occ,        // slot currently holds a live entry
  input  logic   prev_disp,  // neighbour towards the head gives way too
  input  entry_t prev_ent,
  input  entry_t next_ent,
  output logic   disp,
  output entry_t ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  // Give way to the new item when empty or of strictly lower priority
  assign disp = !occ || ($signed(ent_r.prio) < $signed(cmd.item.prio));
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins && disp) begin
      // first slot giving way takes the new item, the rest shift tailwards
      ent_nxt = prev_disp ? prev_ent : cmd.item;
    end else if (cmd.rem) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
